// File: hdl/arm_pkg.sv
package arm_pkg;

    localparam logic [2:0] KIND_ADD_MODULE = 3'd0;
    localparam logic [2:0] KIND_ADD_ALLOC  = 3'd1;
    localparam logic [2:0] KIND_ADD_WRITE  = 3'd2;
    localparam logic [2:0] KIND_QRY_PROG   = 3'd3;
    localparam logic [2:0] KIND_QRY_WRITE  = 3'd4;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_DUP  = 2'd2;

    localparam int ADDR_W = 64;
    localparam int SIZE_W = 32;
    localparam int MOD_W  = 2 * ADDR_W;
    localparam int SZD_W  = ADDR_W + SIZE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef enum logic [1:0] {
        TBL_MOD,
        TBL_ALLOC,
        TBL_WRITE
    } tbl_t;

    function automatic logic sized_match(input logic [SZD_W-1:0] entry,
                                         input logic [ADDR_W-1:0] probe,
                                         input logic insert);
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        lo = entry[SZD_W-1:SIZE_W];
        hi = lo + {{(ADDR_W - SIZE_W){1'b0}}, entry[SIZE_W-1:0]};
        if (insert)
        begin
            return lo == probe;
        end
        return (probe >= lo) && (probe <= hi);
    endfunction

endpackage

// File: hdl/arm_ram.sv
module arm_ram
    import arm_pkg::*;
#(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/arm_match.sv
module arm_match
    import arm_pkg::*;
(
    input  tbl_t              tbl,
    input  logic              insert,
    input  logic [ADDR_W-1:0] probe,
    input  logic [MOD_W-1:0]  mod_data,
    input  logic [SZD_W-1:0]  alloc_data,
    input  logic [SZD_W-1:0]  write_data,
    output logic              match
);

    always_comb
    begin
        unique case (tbl)
            TBL_MOD:
            begin
                match = (probe >= mod_data[MOD_W-1:ADDR_W]) &&
                        (probe <= mod_data[ADDR_W-1:0]);
            end
            TBL_ALLOC:
            begin
                match = sized_match(alloc_data, probe, insert);
            end
            TBL_WRITE:
            begin
                match = sized_match(write_data, probe, insert);
            end
            default:
            begin
                match = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/address_region_membership_table.sv
// Module inserts and unknown kinds give their result in the cycle after the request.
// Other requests scan their table through its memory read port, one entry a cycle;
// a program query scans the module table, then the allocated table if no module matched.
// One request is in flight at a time; busy is high during a table scan until the result strobe.
// Reset clears the table counts and the control state; the memories are not cleared.
// The result appears for one cycle on done and the receiver cannot stall it.
module address_region_membership_table
    import arm_pkg::*;
#(
    parameter int MODULE_ENTRIES   = 16,
    parameter int ALLOC_ENTRIES    = 64,
    parameter int WRITABLE_ENTRIES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        kind,
    input  logic [ADDR_W-1:0] address,
    input  logic [ADDR_W-1:0] high_address,
    input  logic [SIZE_W-1:0] size,
    output logic              done,
    output logic              hit,
    output logic [1:0]        status
);

    localparam int MOD_AW = (MODULE_ENTRIES > 1) ? $clog2(MODULE_ENTRIES) : 1;
    localparam int ALC_AW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
    localparam int WR_AW  = (WRITABLE_ENTRIES > 1) ? $clog2(WRITABLE_ENTRIES) : 1;
    localparam int MOD_CW = $clog2(MODULE_ENTRIES + 1);
    localparam int ALC_CW = $clog2(ALLOC_ENTRIES + 1);
    localparam int WR_CW  = $clog2(WRITABLE_ENTRIES + 1);
    localparam int IDXW_A = (MOD_CW > ALC_CW) ? MOD_CW : ALC_CW;
    localparam int IDXW   = (IDXW_A > WR_CW) ? IDXW_A : WR_CW;

    state_t            state_reg, state_next;
    tbl_t              tbl_reg, tbl_next;
    logic [2:0]        kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [IDXW-1:0]   idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              match_reg, match_next;
    logic [MOD_CW-1:0] mod_cnt_reg, mod_cnt_next;
    logic [ALC_CW-1:0] alc_cnt_reg, alc_cnt_next;
    logic [WR_CW-1:0]  wr_cnt_reg, wr_cnt_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [1:0]        status_reg, status_next;

    logic              accept;
    logic              scan_kind;
    logic              is_insert;
    logic              issue;
    logic              table_end;
    logic              go_alloc;
    logic [IDXW-1:0]   cnt_sel;
    logic              mod_full, alc_full, wr_full;
    logic              match_w;

    logic              mod_we, alc_we, wr_we;
    logic              mod_re, alc_re, wr_re;
    logic [MOD_W-1:0]  mod_rdata;
    logic [SZD_W-1:0]  alc_rdata, wr_rdata;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && (state_reg == ST_IDLE);
    assign scan_kind = (kind == KIND_ADD_ALLOC) || (kind == KIND_ADD_WRITE) ||
                       (kind == KIND_QRY_PROG) || (kind == KIND_QRY_WRITE);
    assign is_insert = (kind_reg == KIND_ADD_ALLOC) || (kind_reg == KIND_ADD_WRITE);

    assign mod_full = mod_cnt_reg == MOD_CW'(MODULE_ENTRIES);
    assign alc_full = alc_cnt_reg == ALC_CW'(ALLOC_ENTRIES);
    assign wr_full  = wr_cnt_reg == WR_CW'(WRITABLE_ENTRIES);

    always_comb
    begin
        unique case (tbl_reg)
            TBL_MOD:   cnt_sel = IDXW'(mod_cnt_reg);
            TBL_ALLOC: cnt_sel = IDXW'(alc_cnt_reg);
            TBL_WRITE: cnt_sel = IDXW'(wr_cnt_reg);
            default:   cnt_sel = '0;
        endcase
    end

    assign issue     = (state_reg == ST_SCAN) && (idx_reg < cnt_sel);
    assign table_end = (state_reg == ST_SCAN) && !issue && !pend_reg;
    assign go_alloc  = (tbl_reg == TBL_MOD) && !match_reg;

    assign mod_re = issue && (tbl_reg == TBL_MOD);
    assign alc_re = issue && (tbl_reg == TBL_ALLOC);
    assign wr_re  = issue && (tbl_reg == TBL_WRITE);

    assign mod_we = accept && (kind == KIND_ADD_MODULE) && !mod_full;
    assign alc_we = table_end && (tbl_reg == TBL_ALLOC) && is_insert &&
                    !match_reg && !alc_full;
    assign wr_we  = table_end && (tbl_reg == TBL_WRITE) && is_insert &&
                    !match_reg && !wr_full;

    arm_ram #(.WIDTH(MOD_W), .DEPTH(MODULE_ENTRIES), .AW(MOD_AW)) u_mod_ram
    (
        .clk   (clk),
        .we    (mod_we),
        .waddr (mod_cnt_reg[MOD_AW-1:0]),
        .wdata ({address, high_address}),
        .re    (mod_re),
        .raddr (idx_reg[MOD_AW-1:0]),
        .rdata (mod_rdata)
    );

    arm_ram #(.WIDTH(SZD_W), .DEPTH(ALLOC_ENTRIES), .AW(ALC_AW)) u_alloc_ram
    (
        .clk   (clk),
        .we    (alc_we),
        .waddr (alc_cnt_reg[ALC_AW-1:0]),
        .wdata ({addr_reg, size_reg}),
        .re    (alc_re),
        .raddr (idx_reg[ALC_AW-1:0]),
        .rdata (alc_rdata)
    );

    arm_ram #(.WIDTH(SZD_W), .DEPTH(WRITABLE_ENTRIES), .AW(WR_AW)) u_write_ram
    (
        .clk   (clk),
        .we    (wr_we),
        .waddr (wr_cnt_reg[WR_AW-1:0]),
        .wdata ({addr_reg, size_reg}),
        .re    (wr_re),
        .raddr (idx_reg[WR_AW-1:0]),
        .rdata (wr_rdata)
    );

    arm_match u_match
    (
        .tbl        (tbl_reg),
        .insert     (is_insert),
        .probe      (addr_reg),
        .mod_data   (mod_rdata),
        .alloc_data (alc_rdata),
        .write_data (wr_rdata),
        .match      (match_w)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && scan_kind)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (table_end && !go_alloc)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tbl_next     = tbl_reg;
        idx_next     = idx_reg;
        pend_next    = issue;
        match_next   = match_reg;
        mod_cnt_next = mod_cnt_reg;
        alc_cnt_next = alc_cnt_reg;
        wr_cnt_next  = wr_cnt_reg;
        done_next    = 1'b0;
        hit_next     = 1'b0;
        status_next  = STATUS_DONE;

        if (accept)
        begin
            idx_next   = '0;
            match_next = 1'b0;
            if (kind == KIND_ADD_ALLOC)
            begin
                tbl_next = TBL_ALLOC;
            end
            else if (kind == KIND_QRY_PROG)
            begin
                tbl_next = TBL_MOD;
            end
            else
            begin
                tbl_next = TBL_WRITE;
            end
            if (!scan_kind)
            begin
                done_next = 1'b1;
                if (kind == KIND_ADD_MODULE)
                begin
                    if (mod_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        mod_cnt_next = mod_cnt_reg + MOD_CW'(1);
                    end
                end
            end
        end

        if (issue)
        begin
            idx_next = idx_reg + IDXW'(1);
        end

        if (pend_reg && match_w)
        begin
            match_next = 1'b1;
        end

        if (table_end)
        begin
            if (go_alloc)
            begin
                tbl_next = TBL_ALLOC;
                idx_next = '0;
            end
            else
            begin
                done_next = 1'b1;
                if (is_insert)
                begin
                    if (match_reg)
                    begin
                        status_next = STATUS_DUP;
                    end
                    else if ((tbl_reg == TBL_ALLOC) ? alc_full : wr_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                end
                else
                begin
                    hit_next = match_reg;
                end
                if (alc_we)
                begin
                    alc_cnt_next = alc_cnt_reg + ALC_CW'(1);
                end
                if (wr_we)
                begin
                    wr_cnt_next = wr_cnt_reg + WR_CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tbl_reg     <= TBL_MOD;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            match_reg   <= 1'b0;
            mod_cnt_reg <= '0;
            alc_cnt_reg <= '0;
            wr_cnt_reg  <= '0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            status_reg  <= STATUS_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            tbl_reg     <= tbl_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            match_reg   <= match_next;
            mod_cnt_reg <= mod_cnt_next;
            alc_cnt_reg <= alc_cnt_next;
            wr_cnt_reg  <= wr_cnt_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            size_reg <= size;
        end
    end

    assign done   = done_reg;
    assign hit    = hit_reg;
    assign status = status_reg;

endmodule
